// ----- rtl/core/ard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types and codes of the address region decoder.
// ----------------------------------------------------------------------------
package ard_pkg;

   localparam int NUM_REGIONS_DEF = 8;
   localparam int ADDR_WIDTH_DEF  = 16;
   localparam int TARGET_WIDTH    = 4;
   localparam int STATUS_WIDTH    = 3;
   localparam int ACTION_WIDTH    = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_DECODE  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_MOUNT   = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_UNMOUNT = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR   = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STS_UNMAPPED  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STS_OCCUPIED  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STS_NO_REGION = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STS_FULL      = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_RES
   } state_type;

   // Per-slot compare results, also used as the running "seen" flags of the chain.
   typedef struct packed {
      logic hit;
      logic free;
      logic match;
      logic ovl;
   } flags_type;

   // Table update broadcast to all cells at commit.
   typedef struct packed {
      logic mount;
      logic unmount;
      logic clear;
   } cmd_type;

endpackage

// ----- rtl/core/address_region_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_region_decoder
// Region table with decode, mount, unmount and clear transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: action, address, region_size, target_id.
//   rsp_* returns exactly one result per transaction: status, hit_target,
//   offset and the total mapped size after the transaction.
//   The table is a row of NUM_REGIONS slot cells. A transaction is compared
//   in every cell in ST_CMP; in ST_RES, which follows, the first-hit,
//   first-free and first-match selections ripple along the cells and,
//   once the output register is free, the table is updated and the result
//   is registered.
//   The next transaction is taken in the cycle that commits the current
//   one, since its compare needs the updated table.
//   A result stalled in the output register holds the commit of the next
//   transaction, and no further transaction is accepted until that commit.
//   Reset empties the table, zeroes the total and drops any pending result.
// ----------------------------------------------------------------------------
module address_region_decoder #(
   parameter int NUM_REGIONS = ard_pkg::NUM_REGIONS_DEF,
   parameter int ADDR_WIDTH  = ard_pkg::ADDR_WIDTH_DEF,
   localparam int REQ_BITS   = ard_pkg::ACTION_WIDTH + 2 * ADDR_WIDTH + 1
                               + ard_pkg::TARGET_WIDTH,
   localparam int REQ_WIDTH  = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ard_pkg::STATUS_WIDTH + ard_pkg::TARGET_WIDTH
                               + 2 * ADDR_WIDTH + 1,
   localparam int RSP_WIDTH  = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // action, address, region_size, target_id (from bit 0), zero padded
   input  logic [REQ_WIDTH-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // status, hit_target, offset, total_mapped (from bit 0), zero padded
   output logic [RSP_WIDTH-1:0] rsp_tdata
);

   localparam int AW = ADDR_WIDTH;
   localparam int TW = ard_pkg::TARGET_WIDTH;
   localparam logic [AW+1:0] SPACE_SIZE = {2'b01, {AW{1'b0}}};

   ard_pkg::state_type state_ff, state_in;

   logic [ard_pkg::ACTION_WIDTH-1:0] action_ff;
   logic [AW-1:0]                    address_ff;
   logic [AW:0]                      size_ff;
   logic [TW-1:0]                    target_ff;

   logic [AW:0]                      total_ff, total_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]              rsp_data_ff, rsp_data_in;

   logic                             accept, commit, cmp_en, out_free;
   logic [AW+1:0]                    end_sum;
   logic                             range_ok;
   ard_pkg::cmd_type                 cmd;

   ard_pkg::flags_type               seen_chain   [NUM_REGIONS+1];
   logic [TW-1:0]                    target_chain [NUM_REGIONS+1];
   logic [AW-1:0]                    offset_chain [NUM_REGIONS+1];
   logic [AW:0]                      drop_chain   [NUM_REGIONS+1];

   logic [ard_pkg::STATUS_WIDTH-1:0] status;
   logic [TW-1:0]                    hit_target;
   logic [AW-1:0]                    hit_offset;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ard_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ard_pkg::ST_CMP;
            end
         end
         ard_pkg::ST_CMP: begin
            state_in = ard_pkg::ST_RES;
         end
         ard_pkg::ST_RES: begin
            if (commit) begin
               state_in = accept ? ard_pkg::ST_CMP : ard_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ard_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      cmp_en     = 1'b0;
      commit     = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ard_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         ard_pkg::ST_CMP: begin
            cmp_en = 1'b1;
         end
         ard_pkg::ST_RES: begin
            commit     = out_free;
            req_tready = out_free;
         end
         default: begin
            cmp_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ard_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= req_tdata[ard_pkg::ACTION_WIDTH-1:0];
         address_ff <= req_tdata[AW+1:2];
         size_ff    <= req_tdata[2*AW+2:AW+2];
         target_ff  <= req_tdata[2*AW+TW+2:2*AW+3];
      end
   end

   assign end_sum  = {2'b00, address_ff} + {1'b0, size_ff};
   assign range_ok = (size_ff != '0) && (end_sum <= SPACE_SIZE);

   assign seen_chain[0]   = '0;
   assign target_chain[0] = '0;
   assign offset_chain[0] = '0;
   assign drop_chain[0]   = '0;

   for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
      ard_cell #(
         .ADDR_WIDTH(ADDR_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmp_en        (cmp_en),
         .req_addr      (address_ff),
         .req_end       (end_sum[AW:0]),
         .req_target    (target_ff),
         .cmd           (cmd),
         .seen_in       (seen_chain[i]),
         .seen_out      (seen_chain[i+1]),
         .hit_target_in (target_chain[i]),
         .hit_target_out(target_chain[i+1]),
         .hit_offset_in (offset_chain[i]),
         .hit_offset_out(offset_chain[i+1]),
         .drop_size_in  (drop_chain[i]),
         .drop_size_out (drop_chain[i+1])
      );
   end

   always_comb begin
      cmd        = '0;
      status     = ard_pkg::STS_OK;
      hit_target = '0;
      hit_offset = '0;
      total_in   = total_ff;
      unique case (action_ff)
         ard_pkg::ACT_DECODE: begin
            if (seen_chain[NUM_REGIONS].hit) begin
               hit_target = target_chain[NUM_REGIONS];
               hit_offset = offset_chain[NUM_REGIONS];
            end else begin
               status = ard_pkg::STS_UNMAPPED;
            end
         end
         ard_pkg::ACT_MOUNT: begin
            priority if (!range_ok) begin
               status = ard_pkg::STS_UNMAPPED;
            end else if (seen_chain[NUM_REGIONS].ovl) begin
               status = ard_pkg::STS_OCCUPIED;
            end else if (!seen_chain[NUM_REGIONS].free) begin
               status = ard_pkg::STS_FULL;
            end else begin
               cmd.mount = commit;
               total_in  = total_ff + size_ff;
            end
         end
         ard_pkg::ACT_UNMOUNT: begin
            if (seen_chain[NUM_REGIONS].match) begin
               cmd.unmount = commit;
               total_in    = total_ff - drop_chain[NUM_REGIONS];
            end else begin
               status = ard_pkg::STS_NO_REGION;
            end
         end
         ard_pkg::ACT_CLEAR: begin
            cmd.clear = commit;
            total_in  = '0;
         end
         default: begin
            status = ard_pkg::STS_OK;
         end
      endcase
   end

   assign rsp_data_in  = {total_in, hit_offset, hit_target, status};
   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(rsp_data_ff);

endmodule

// ----- rtl/core/ard_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_cell
// One region slot: holds start, end and target, compares the current
// transaction and passes the first-hit, first-free and first-match selections to the next cell.
// ----------------------------------------------------------------------------
module ard_cell #(
   parameter int ADDR_WIDTH = ard_pkg::ADDR_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmp_en,
   input  logic [ADDR_WIDTH-1:0]             req_addr,
   input  logic [ADDR_WIDTH:0]               req_end,
   input  logic [ard_pkg::TARGET_WIDTH-1:0]  req_target,
   input  ard_pkg::cmd_type                  cmd,
   input  ard_pkg::flags_type                seen_in,
   output ard_pkg::flags_type                seen_out,
   input  logic [ard_pkg::TARGET_WIDTH-1:0]  hit_target_in,
   output logic [ard_pkg::TARGET_WIDTH-1:0]  hit_target_out,
   input  logic [ADDR_WIDTH-1:0]             hit_offset_in,
   output logic [ADDR_WIDTH-1:0]             hit_offset_out,
   input  logic [ADDR_WIDTH:0]               drop_size_in,
   output logic [ADDR_WIDTH:0]               drop_size_out
);

   logic                             valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0]            start_ff;
   logic [ADDR_WIDTH:0]              end_ff;
   logic [ard_pkg::TARGET_WIDTH-1:0] target_ff;
   ard_pkg::flags_type               flags_ff, flags_in;
   logic [ADDR_WIDTH-1:0]            offset_ff, offset_in;
   logic [ADDR_WIDTH:0]              size_ff, size_in;
   logic                             hit_sel, free_sel, match_sel;
   logic [ADDR_WIDTH:0]              addr_ext;

   assign addr_ext = {1'b0, req_addr};

   always_comb begin
      flags_in.hit   = valid_ff && (req_addr >= start_ff) && (addr_ext < end_ff);
      flags_in.free  = !valid_ff;
      flags_in.match = valid_ff && (start_ff == req_addr);
      flags_in.ovl   = valid_ff && (addr_ext < end_ff) && ({1'b0, start_ff} < req_end);
      offset_in      = req_addr - start_ff;
      size_in        = end_ff - {1'b0, start_ff};
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         flags_ff  <= flags_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
      end
   end

   assign hit_sel   = flags_ff.hit   && !seen_in.hit;
   assign free_sel  = flags_ff.free  && !seen_in.free;
   assign match_sel = flags_ff.match && !seen_in.match;

   always_comb begin
      seen_out.hit   = seen_in.hit   | flags_ff.hit;
      seen_out.free  = seen_in.free  | flags_ff.free;
      seen_out.match = seen_in.match | flags_ff.match;
      seen_out.ovl   = seen_in.ovl   | flags_ff.ovl;
      hit_target_out = hit_target_in | (hit_sel ? target_ff : '0);
      hit_offset_out = hit_offset_in | (hit_sel ? offset_ff : '0);
      drop_size_out  = drop_size_in  | (match_sel ? size_ff : '0);
   end

   always_comb begin
      priority if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.mount && free_sel) begin
         valid_in = 1'b1;
      end else if (cmd.unmount && match_sel) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mount && free_sel) begin
         start_ff  <= req_addr;
         end_ff    <= req_end;
         target_ff <= req_target;
      end
   end

endmodule

// ----- rtl/core/ard_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ard_checker
// Port-level checks of the address region decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ard_checker #(
   parameter int ADDR_WIDTH = ard_pkg::ADDR_WIDTH_DEF,
   localparam int RSP_BITS  = ard_pkg::STATUS_WIDTH + ard_pkg::TARGET_WIDTH
                              + 2 * ADDR_WIDTH + 1,
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_WIDTH-1:0] rsp_tdata
);

   localparam int AW = ADDR_WIDTH;
   localparam logic [AW:0] SPACE_SIZE = {1'b1, {AW{1'b0}}};

   logic [ard_pkg::STATUS_WIDTH-1:0] status;
   logic [ard_pkg::TARGET_WIDTH-1:0] hit_target;
   logic [AW-1:0]                    hit_offset;
   logic [AW:0]                      total;
   logic                             req_accept;

   assign status     = rsp_tdata[2:0];
   assign hit_target = rsp_tdata[6:3];
   assign hit_offset = rsp_tdata[AW+6:7];
   assign total      = rsp_tdata[2*AW+7:AW+7];
   assign req_accept = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("transaction accepted in the cycle after acceptance");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status <= ard_pkg::STS_FULL)
      else $error("undefined status code");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ard_pkg::STS_OK |-> hit_target == '0 && hit_offset == '0)
      else $error("target or offset set on a failed transaction");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> total <= SPACE_SIZE)
      else $error("mapped total exceeds the address space");

endmodule

bind address_region_decoder ard_checker #(
   .ADDR_WIDTH(ADDR_WIDTH)
) u_ard_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
